/* hw/rtl/divider_and_reload_timer_top_defines.svh */
// ----------------------------------------------------------------------------
// divider and reload timer assertion macros
// shared concurrent assertion forms, clocked on aclk, held off in reset
// ----------------------------------------------------------------------------
`ifndef DIVIDER_AND_RELOAD_TIMER_TOP_DEFINES_SVH
`define DIVIDER_AND_RELOAD_TIMER_TOP_DEFINES_SVH

// same-cycle implication
`define DRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// next-cycle implication
`define DRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

/* hw/rtl/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// types, codes and helpers shared by the divider and reload timer
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int OFS_W    = 2;
    localparam int RATE_W   = 2;
    localparam int PHASE_W  = 11;
    localparam int STEPS_W  = 7;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [OFS_W-1:0] REG_DIV  = 2'd0;
    localparam logic [OFS_W-1:0] REG_CNT  = 2'd1;
    localparam logic [OFS_W-1:0] REG_MOD  = 2'd2;
    localparam logic [OFS_W-1:0] REG_CTRL = 2'd3;

    // period codes for the four timer rates
    localparam logic [RATE_W-1:0] RATE_1024 = 2'd0;
    localparam logic [RATE_W-1:0] RATE_16   = 2'd1;
    localparam logic [RATE_W-1:0] RATE_64   = 2'd2;
    localparam logic [RATE_W-1:0] RATE_256  = 2'd3;

    // control read shows the upper five bits as ones
    localparam logic [4:0] CTRL_FIXED_ONES = 5'b11111;
    localparam int         CTRL_EN_BIT     = 2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] cycles;
        logic [OFS_W-1:0]  reg_offset;
        logic [BYTE_W-1:0] wdata;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              timer_irq;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic steps_zero;
    } dp_sts_t;

    // number of whole periods held in the phase sum
    function automatic logic [STEPS_W-1:0] rate_steps(input logic [RATE_W-1:0] rate,
                                                      input logic [PHASE_W-1:0] sum);
        logic [STEPS_W-1:0] res;
        case (rate)
            RATE_1024: res = {6'd0, sum[10]};
            RATE_16:   res = sum[10:4];
            RATE_64:   res = {2'd0, sum[10:6]};
            RATE_256:  res = {4'd0, sum[10:8]};
            default:   res = '0;
        endcase
        return res;
    endfunction

    // phase left over after the whole periods
    function automatic logic [PHASE_W-1:0] rate_rem(input logic [RATE_W-1:0] rate,
                                                    input logic [PHASE_W-1:0] sum);
        logic [PHASE_W-1:0] res;
        case (rate)
            RATE_1024: res = {1'b0, sum[9:0]};
            RATE_16:   res = {7'd0, sum[3:0]};
            RATE_64:   res = {5'd0, sum[5:0]};
            RATE_256:  res = {3'd0, sum[7:0]};
            default:   res = '0;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/divider_and_reload_timer_top.sv */
// ----------------------------------------------------------------------------
// divider_and_reload_timer_top
// divider and reload timer peripheral with valid/ready item and result channels
// ----------------------------------------------------------------------------
// Each input beat is a tick, a register read or a register write, and gives
// exactly one result beat. Reads, writes and the unused kind code load their
// result into the output register at acceptance. A tick first runs N counter
// steps, where N is the number of whole timer periods in the timer phase plus
// the tick's cycles (zero while the timer is disabled): the counter has a
// single incrementer with reload and takes one step per clock, so N reaches 16
// for the largest tick at the fastest rate and at most 79 after a rate change
// leaves a large phase behind. One item is in flight at a time; a new beat is
// taken while the previous result is being drained.
// The divider needs no iteration since a tick adds at most one divider step.
// ----------------------------------------------------------------------------
`include "divider_and_reload_timer_top_defines.svh"

module divider_and_reload_timer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  drt_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output drt_pkg::out_item_t  m_data
);
    import drt_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: handshake, tick stepping, result valid
    drt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_kind (s_data.kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath: timer state, register file, result register
    drt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

    // a non-tick beat shows its result in the next cycle
    `DRT_ASSERT_NEXT(a_direct_result, s_valid && s_ready && s_data.kind != KIND_TICK, m_valid)
    // a result carries either read data or an interrupt, never both
    `DRT_ASSERT_NOW(a_result_exclusive, m_valid && m_data.timer_irq, m_data.rdata == '0)
    // no beat is taken while a stalled result occupies the output register
    `DRT_ASSERT_NOW(a_no_overrun, m_valid && !m_ready, !s_ready)
    // a counter step never coincides with acceptance
    `DRT_ASSERT_NOW(a_step_exclusive, cmd.step, !cmd.start && !cmd.finish)

endmodule

/* hw/rtl/drt_ctrl.sv */
// ----------------------------------------------------------------------------
// drt_ctrl
// sequencer: accepts beats, runs counter steps, owns the result valid
// ----------------------------------------------------------------------------
module drt_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [drt_pkg::KIND_W-1:0]   in_kind,
    output logic                         m_valid,
    input  logic                         m_ready,
    output drt_pkg::dp_cmd_t             cmd,
    input  drt_pkg::dp_sts_t             sts
);
    import drt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.start  = accept;
        cmd.step   = (state_reg == ST_RUN) && !sts.steps_zero;
        cmd.finish = (state_reg == ST_RUN) && sts.steps_zero && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_kind == KIND_TICK) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish || (accept && in_kind != KIND_TICK)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hw/rtl/drt_dp.sv */
// ----------------------------------------------------------------------------
// drt_dp
// divider, phase accumulators, counter with reload, registers, result buffer
// ----------------------------------------------------------------------------
module drt_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  drt_pkg::in_item_t    s_data,
    input  drt_pkg::dp_cmd_t     cmd,
    output drt_pkg::dp_sts_t     sts,
    output drt_pkg::out_item_t   m_data
);
    import drt_pkg::*;

    logic [BYTE_W-1:0]  div_phase_reg, div_phase_next;
    logic [BYTE_W-1:0]  div_value_reg, div_value_next;
    logic [PHASE_W-1:0] timer_phase_reg, timer_phase_next;
    logic [BYTE_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]  reload_reg, reload_next;
    logic               run_en_reg, run_en_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic               irq_reg, irq_next;
    out_item_t          out_reg, out_next;

    logic [BYTE_W:0]    div_sum;
    logic [PHASE_W-1:0] tmr_sum;
    logic [BYTE_W-1:0]  rd_mux;

    assign div_sum = {1'b0, div_phase_reg} + {1'b0, s_data.cycles};
    assign tmr_sum = timer_phase_reg + {{(PHASE_W-BYTE_W){1'b0}}, s_data.cycles};

    always_comb begin
        case (s_data.reg_offset)
            REG_DIV:  rd_mux = div_value_reg;
            REG_CNT:  rd_mux = count_reg;
            REG_MOD:  rd_mux = reload_reg;
            REG_CTRL: rd_mux = {CTRL_FIXED_ONES, run_en_reg, rate_reg};
            default:  rd_mux = '0;
        endcase
    end

    always_comb begin
        div_phase_next   = div_phase_reg;
        div_value_next   = div_value_reg;
        timer_phase_next = timer_phase_reg;
        count_next       = count_reg;
        reload_next      = reload_reg;
        run_en_next      = run_en_reg;
        rate_next        = rate_reg;
        steps_next       = steps_reg;
        irq_next         = irq_reg;
        out_next         = out_reg;

        if (cmd.start) begin
            out_next = '0;
            case (s_data.kind)
                KIND_TICK: begin
                    // at most one divider step per tick
                    div_phase_next = div_sum[BYTE_W-1:0];
                    div_value_next = div_value_reg + {{(BYTE_W-1){1'b0}}, div_sum[BYTE_W]};
                    irq_next       = 1'b0;
                    if (run_en_reg) begin
                        steps_next       = rate_steps(rate_reg, tmr_sum);
                        timer_phase_next = rate_rem(rate_reg, tmr_sum);
                    end else begin
                        steps_next = '0;
                    end
                end
                KIND_READ: begin
                    out_next.rdata = rd_mux;
                end
                KIND_WRITE: begin
                    case (s_data.reg_offset)
                        REG_DIV: begin
                            div_value_next   = '0;
                            timer_phase_next = '0;
                        end
                        REG_CNT:  count_next  = s_data.wdata;
                        REG_MOD:  reload_next = s_data.wdata;
                        REG_CTRL: begin
                            run_en_next = s_data.wdata[CTRL_EN_BIT];
                            rate_next   = s_data.wdata[RATE_W-1:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        if (cmd.step) begin
            steps_next = steps_reg - {{(STEPS_W-1){1'b0}}, 1'b1};
            if (count_reg == {BYTE_W{1'b1}}) begin
                count_next = reload_reg;
                irq_next   = 1'b1;
            end else begin
                count_next = count_reg + {{(BYTE_W-1){1'b0}}, 1'b1};
            end
        end

        if (cmd.finish) begin
            out_next.rdata     = '0;
            out_next.timer_irq = irq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_phase_reg   <= '0;
            div_value_reg   <= '0;
            timer_phase_reg <= '0;
            count_reg       <= '0;
            reload_reg      <= '0;
            run_en_reg      <= 1'b0;
            rate_reg        <= RATE_1024;
            steps_reg       <= '0;
            irq_reg         <= 1'b0;
        end else begin
            div_phase_reg   <= div_phase_next;
            div_value_reg   <= div_value_next;
            timer_phase_reg <= timer_phase_next;
            count_reg       <= count_next;
            reload_reg      <= reload_next;
            run_en_reg      <= run_en_next;
            rate_reg        <= rate_next;
            steps_reg       <= steps_next;
            irq_reg         <= irq_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign sts.steps_zero = (steps_reg == '0);
    assign m_data         = out_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider and reload timer testbench
// drives tick, register read, register write and unused-kind beats through
// the valid/ready item channel, predicts every result beat in a scoreboard
// and checks each one in order; random idling on both sides, one long result
// hold-off
module testbench;
    import drt_pkg::*;

    // kind code with no function: the block must answer it with an all-zero result
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;   // margin beyond the longest tick
    localparam int RANDOM_ITEMS = 950;
    localparam int CHUNK        = 50;    // idling mode is redrawn per chunk
    localparam int LONG_HOLD    = 300;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of the timer state and the queue of
    // results still owed by the block
    // ------------------------------------------------------------------------
    class timer_scoreboard;
        logic [BYTE_W-1:0]  prescale;   // cycles toward the next divider step
        logic [BYTE_W-1:0]  div_byte;
        logic [PHASE_W-1:0] tmr_acc;    // cycles toward the next counter step
        logic [BYTE_W-1:0]  counter;
        logic [BYTE_W-1:0]  modulo;
        logic               enabled;
        logic [RATE_W-1:0]  rate;
        out_item_t          expected_results[$];
        int                 mismatches;

        function new();
            prescale   = '0;
            div_byte   = '0;
            tmr_acc    = '0;
            counter    = '0;
            modulo     = '0;
            enabled    = 1'b0;
            rate       = RATE_1024;
            mismatches = 0;
        endfunction

        // advance the state by one accepted beat and queue its result
        function void note_item(in_item_t it);
            out_item_t          res;
            logic [BYTE_W:0]    div_sum;
            logic [PHASE_W-1:0] period;
            res = '0;
            case (it.kind)
                KIND_TICK: begin
                    // a tick's cycles field is one byte, so at most one divider step
                    div_sum = {1'b0, prescale} + {1'b0, it.cycles};
                    if (div_sum[BYTE_W])
                        div_byte = div_byte + 8'd1;
                    prescale = div_sum[BYTE_W-1:0];
                    if (enabled) begin
                        case (rate)
                            RATE_1024: period = 11'd1024;
                            RATE_16:   period = 11'd16;
                            RATE_64:   period = 11'd64;
                            RATE_256:  period = 11'd256;
                            default:   period = 11'd1024;
                        endcase
                        tmr_acc = tmr_acc + {{(PHASE_W-BYTE_W){1'b0}}, it.cycles};
                        while (tmr_acc >= period) begin
                            counter = counter + 8'd1;
                            if (counter == 8'd0) begin
                                counter       = modulo;
                                res.timer_irq = 1'b1;
                            end
                            tmr_acc = tmr_acc - period;
                        end
                    end
                end
                KIND_READ: begin
                    case (it.reg_offset)
                        REG_DIV:  res.rdata = div_byte;
                        REG_CNT:  res.rdata = counter;
                        REG_MOD:  res.rdata = modulo;
                        REG_CTRL: res.rdata = {CTRL_FIXED_ONES, enabled, rate};
                        default:  res.rdata = '0;
                    endcase
                end
                KIND_WRITE: begin
                    case (it.reg_offset)
                        REG_DIV: begin
                            // data ignored, prescale kept
                            div_byte = '0;
                            tmr_acc  = '0;
                        end
                        REG_CNT:  counter = it.wdata;
                        REG_MOD:  modulo  = it.wdata;
                        REG_CTRL: begin
                            enabled = it.wdata[CTRL_EN_BIT];
                            rate    = it.wdata[RATE_W-1:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing pending: rdata %02h timer_irq %0b",
                         $time, got.rdata, got.timer_irq);
                return;
            end
            want = expected_results.pop_front();
            if (got.rdata !== want.rdata) begin
                mismatches++;
                $display("%0t: rdata mismatch: expected %02h, actual %02h",
                         $time, want.rdata, got.rdata);
            end
            if (got.timer_irq !== want.timer_irq) begin
                mismatches++;
                $display("%0t: timer_irq mismatch: expected %0b, actual %0b",
                         $time, want.timer_irq, got.timer_irq);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    timer_scoreboard sb = new();

    // idling control shared by the sender and the receiver
    bit idle_mode;       // random bursts allowed on both sides
    bit long_hold_req;   // receiver holds off for the one long hold-off
    int cycle_count;

    divider_and_reload_timer_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit, far above the slowest legal run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("divider_and_reload_timer_top test failed");
            $finish;
        end
    end

    // monitor: both channels sampled at the edge where the beat moves;
    // the result is checked before the new item is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_item(s_data);
        end
    end

    // offer one beat, hold it until accepted, then maybe go quiet for a burst
    task automatic drive_beat(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] cyc,
                              input logic [OFS_W-1:0] ofs, input logic [BYTE_W-1:0] wd);
        in_item_t it;
        it.kind       = kind;
        it.cycles     = cyc;
        it.reg_offset = ofs;
        it.wdata      = wd;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (idle_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // receiver: random stall bursts, plus the one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                // block fills up and must drop s_ready while the sender keeps offering
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_mode && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        int                pick;
        logic [BYTE_W-1:0] cyc;
        logic [BYTE_W-1:0] wd;
        logic [OFS_W-1:0]  ofs;

        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_mode = 1'b1;

        // --- directed part ---
        // reset values, control read shows the fixed upper ones
        drive_beat(KIND_READ,   8'h00, REG_CTRL, 8'h00);
        drive_beat(KIND_READ,   8'hFF, REG_CNT,  8'hFF);
        // unused kind with every field at its top: no state change, zero result
        drive_beat(KIND_UNUSED, 8'hFF, REG_CTRL, 8'hFF);
        // timer disabled: only the divider moves
        drive_beat(KIND_TICK,   8'h00, REG_DIV,  8'h00);
        drive_beat(KIND_TICK,   8'hFF, REG_DIV,  8'h00);
        drive_beat(KIND_TICK,   8'h01, REG_DIV,  8'h00);
        drive_beat(KIND_WRITE,  8'h00, REG_MOD,  8'hFF);
        drive_beat(KIND_WRITE,  8'h00, REG_CNT,  8'hF0);
        // upper control bits dropped: enable, RATE_16 code
        drive_beat(KIND_WRITE,  8'h00, REG_CTRL, 8'hFD);
        drive_beat(KIND_READ,   8'h00, REG_CTRL, 8'h00);
        // 15 steps to ff, then one step wraps
        drive_beat(KIND_TICK,   8'hFF, REG_DIV,  8'h00);
        drive_beat(KIND_TICK,   8'h01, REG_DIV,  8'h00);
        // modulo ff: every step wraps, still a single irq
        drive_beat(KIND_TICK,   8'hFF, REG_DIV,  8'h00);
        // slow rate, divider write clears the timer phase, data ignored
        drive_beat(KIND_WRITE,  8'h00, REG_CTRL, 8'h04);
        drive_beat(KIND_WRITE,  8'h00, REG_DIV,  8'h5A);
        drive_beat(KIND_WRITE,  8'h00, REG_MOD,  8'h00);
        repeat (4) drive_beat(KIND_TICK, 8'hFF, REG_DIV, 8'h00);
        // phase near 1020, switch to the fast rate: next tick takes 79 steps
        drive_beat(KIND_WRITE,  8'h00, REG_CTRL, 8'h05);
        drive_beat(KIND_TICK,   8'hFF, REG_DIV,  8'h00);
        drive_beat(KIND_READ,   8'h00, REG_CNT,  8'h00);
        // disabled again: phase held across the tick
        drive_beat(KIND_WRITE,  8'h00, REG_CTRL, 8'h02);
        drive_beat(KIND_TICK,   8'hC8, REG_DIV,  8'h00);
        drive_beat(KIND_READ,   8'h00, REG_DIV,  8'h00);

        // --- random part ---
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % CHUNK == 0) begin
                // last chunks run with no idling at all
                idle_mode = (n < RANDOM_ITEMS - 3 * CHUNK) && ($urandom_range(0, 3) != 0);
                if (n == 5 * CHUNK) begin
                    idle_mode     = 1'b0;
                    long_hold_req = 1'b1;
                end
            end
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                cyc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                cyc = BYTE_W'($urandom_range(0, 255));
            ofs = OFS_W'($urandom_range(0, 3));
            wd  = BYTE_W'($urandom_range(0, 255));
            if (pick < 68) begin
                drive_beat(KIND_TICK, cyc, ofs, wd);
            end else if (pick < 80) begin
                drive_beat(KIND_READ, cyc, ofs, wd);
            end else if (pick < 97) begin
                // mostly keep the timer running so the counter sees real traffic
                if (ofs == REG_CTRL && $urandom_range(0, 4) != 0)
                    wd[CTRL_EN_BIT] = 1'b1;
                drive_beat(KIND_WRITE, cyc, ofs, wd);
            end else begin
                drive_beat(KIND_UNUSED, cyc, ofs, wd);
            end
        end
        s_valid <= 1'b0;

        // drain: every result back, then a margin for any stray beat
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("divider_and_reload_timer_top test passed");
        else
            $display("divider_and_reload_timer_top test failed");
        $finish;
    end

endmodule
